@@ sv/soil_transmissivity_assert.svh @@
// Assertion macros used by the checker in st_check.sv.
`ifndef SOIL_TRANSMISSIVITY_ASSERT_SVH
`define SOIL_TRANSMISSIVITY_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define ST_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define ST_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/st_pkg.sv @@
package st_pkg;

	// field widths
	localparam int DEP_W = 24;
	localparam int KS_W = 32;
	localparam int T_W = 40;
	localparam int X_W = 48;
	localparam int Q_W = 56;
	localparam int E_W = 33;
	localparam int R_W = 33;
	localparam int L_W = 49;
	localparam int G2_W = 64;

	// exponent span of the table is 2^SPAN_LOG in Q16.32
	localparam int SPAN_LOG = 37;
	localparam logic [63:0] SPAN = 64'd1 << SPAN_LOG;
	localparam logic [T_W-1:0] T_MAX = {T_W{1'b1}};

	typedef enum logic [2:0] {
		RULE_FLAT,
		RULE_UPPER,
		RULE_SHALLOW,
		RULE_BAD,
		RULE_LINEAR
	} rule_t;

	// bits [s+63:s] of a*b + 2^(s-1); used at elaboration only
	function automatic logic [63:0] mul_shift(input logic [63:0] a, input logic [63:0] b,
		input int unsigned s);
		logic [127:0] p;
		logic [127:0] sh;
		p = {64'd0, a} * {64'd0, b};
		p = p + (128'd1 << (s - 1));
		sh = p >> s;
		return sh[63:0];
	endfunction

endpackage

@@ sv/st_div.sv @@
module st_div #(
	parameter int W = 56,
	parameter int DW = 24,
	parameter int CW = 1
) (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_valid,
	input logic [W-1:0] num,
	input logic [DW-1:0] den,
	input logic [CW-1:0] ctx_in,
	output logic out_valid,
	output logic [W-1:0] quo,
	output logic [DW-1:0] rem,
	output logic [CW-1:0] ctx_out
);

	logic vld_s [W];
	logic [DW-1:0] rem_s [W];
	logic [W-1:0] bits_s [W];
	logic [DW-1:0] den_s [W];
	logic [CW-1:0] ctx_s [W];

	// one quotient bit per stage, restoring form
	for (genvar k = 0; k < W; k++) begin : g_stg
		logic [DW-1:0] rem_p;
		logic [DW-1:0] den_p;
		logic [W-1:0] bits_p;
		logic [CW-1:0] ctx_p;
		logic vld_p;
		logic [DW:0] trial;
		logic [DW:0] diff;
		logic ge;

		if (k == 0) begin : g_first
			assign rem_p = '0;
			assign den_p = den;
			assign bits_p = num;
			assign ctx_p = ctx_in;
			assign vld_p = in_valid;
		end else begin : g_next
			assign rem_p = rem_s[k-1];
			assign den_p = den_s[k-1];
			assign bits_p = bits_s[k-1];
			assign ctx_p = ctx_s[k-1];
			assign vld_p = vld_s[k-1];
		end

		assign trial = {rem_p, bits_p[W-1]};
		assign diff = trial - {1'b0, den_p};
		assign ge = (trial >= {1'b0, den_p});

		// advance valid
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_p;
			end
		end

		// subtract when the divisor fits, shift in the quotient bit
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? diff[DW-1:0] : trial[DW-1:0];
				bits_s[k] <= {bits_p[W-2:0], ge};
				den_s[k] <= den_p;
				ctx_s[k] <= ctx_p;
			end
		end
	end

	assign out_valid = vld_s[W-1];
	assign quo = bits_s[W-1];
	assign rem = rem_s[W-1];
	assign ctx_out = ctx_s[W-1];

endmodule

@@ sv/soil_transmissivity.sv @@
// Transmissivity of a saturated soil layer whose conductivity decays
// exponentially with depth.
// Input channel: in_valid / in_stall with soil_depth, water_depth,
// lateral_cond, decay_rate and thresh_depth; a transfer happens on a clock
// edge with in_valid high and in_stall low.
// Output channel: out_valid / out_stall with transmissivity and clamped,
// one result per input item, in order.
// Depth: 67 register stages, from the input registers to the output register.
// Throughput: one item per cycle while no stalled result holds the pipeline.
// The two long dividers (Ks/f and the linear ratio, 56 quotient bits, one bit
// per stage) set the depth.
// EXP_TABLE_DEPTH must be a power of two; table index, remainder and the
// interpolation step are then shifts and masks.
// The whole pipeline advances together; while out_valid is high and
// out_stall is high every stage holds and in_stall is raised, so nothing is
// lost or repeated. Empty stages travel as bubbles.
// Reset (arst_n low) clears all valid bits; the exponential table is a
// constant and needs no fill.
module soil_transmissivity #(
	parameter int EXP_TABLE_DEPTH = 256
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [st_pkg::DEP_W-1:0] soil_depth,
	input logic [st_pkg::DEP_W-1:0] water_depth,
	input logic [st_pkg::KS_W-1:0] lateral_cond,
	input logic [st_pkg::DEP_W-1:0] decay_rate,
	input logic [st_pkg::DEP_W-1:0] thresh_depth,
	output logic out_valid,
	input logic out_stall,
	output logic [st_pkg::T_W-1:0] transmissivity,
	output logic clamped
);

	import st_pkg::*;

	localparam logic [63:0] STEP = SPAN / 64'(EXP_TABLE_DEPTH);
	localparam logic [63:0] X_LIM = STEP * 64'(EXP_TABLE_DEPTH);
	localparam int IW = $clog2(EXP_TABLE_DEPTH);
	localparam int RAW = $clog2(EXP_TABLE_DEPTH + 1);
	localparam int SH = SPAN_LOG - IW;

	// the table step must be a power of two
	if ((1 << IW) != EXP_TABLE_DEPTH) begin : g_depth_chk
		$error("EXP_TABLE_DEPTH must be a power of two");
	end

	typedef logic [E_W-1:0] rom_t [0:EXP_TABLE_DEPTH];

	typedef struct packed {
		rule_t rule;
		logic neg0;
		logic [T_W-1:0] flat;
		logic zt;
		logic zb;
		logic [SPAN_LOG-1:0] xt;
		logic [SPAN_LOG-1:0] xb;
	} c1_t;

	typedef struct packed {
		logic [E_W-1:0] at;
		logic [E_W-1:0] ab;
		logic [Q_W-1:0] q;
		logic [R_W-1:0] ratio;
		c1_t c1;
	} c2_t;

	// samples of e^-(k*STEP/2^32) in Q0.32 from a Q0.62 series
	function automatic rom_t build_rom();
		rom_t rom;
		logic [63:0] u62;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] t62;
		logic [63:0] smp;
		u62 = STEP << 30;
		term = 64'd1 << 62;
		sum = term;
		for (int n = 1; n <= 24; n++) begin
			term = mul_shift(term, u62, 62) / 64'(n);
			if (n % 2 == 1) begin
				sum = sum - term;
			end else begin
				sum = sum + term;
			end
		end
		t62 = 64'd1 << 62;
		rom[0] = E_W'(64'd1 << 32);
		for (int k = 1; k <= EXP_TABLE_DEPTH; k++) begin
			t62 = mul_shift(t62, sum, 62);
			smp = (t62 + (64'd1 << 29)) >> 30;
			rom[k] = smp[E_W-1:0];
		end
		return rom;
	endfunction

	localparam rom_t EXP_ROM = build_rom();

	logic en;
	assign en = !(out_valid && out_stall);
	assign in_stall = !en;

	// ---- stage 1: capture and pick the rule
	logic v_s1;
	logic [DEP_W-1:0] d_s1, z_s1, h_s1, f_s1;
	logic [KS_W-1:0] ks_s1;
	rule_t rule_s1;
	logic neg0_s1;
	rule_t rule_in;

	always_comb begin
		if (decay_rate == '0) begin
			rule_in = RULE_FLAT;
		end else if (water_depth < thresh_depth) begin
			rule_in = RULE_UPPER;
		end else if (soil_depth < thresh_depth) begin
			rule_in = RULE_SHALLOW;
		end else if (soil_depth == thresh_depth || water_depth > soil_depth) begin
			rule_in = RULE_BAD;
		end else begin
			rule_in = RULE_LINEAR;
		end
	end

	// ---- stage 2: exponent arguments and the flat product
	logic v_s2;
	logic [X_W-1:0] xt_s2, xb_s2;
	logic [Q_W-1:0] fl_s2;
	logic [KS_W-1:0] ks_s2;
	logic [DEP_W-1:0] f_s2, dz_s2, dh_s2;
	rule_t rule_s2;
	logic neg0_s2;
	logic [DEP_W-1:0] top_s1;

	assign top_s1 = (rule_s1 == RULE_UPPER) ? z_s1 : h_s1;

	// ---- divider group: Ks/f and linear ratio; exponent arguments ride along
	c1_t c1_in, c1_g1;
	logic [Q_W-1:0] fl_sum;
	logic zt_in, zb_in;
	logic [SPAN_LOG-1:0] xt_num, xb_num;
	logic v_g1;
	logic [Q_W-1:0] q_g1, ratio_g1;
	logic [SH-1:0] rt_g1, rb_g1;

	assign fl_sum = fl_s2 + Q_W'(32768);
	assign zt_in = (64'(xt_s2) >= X_LIM);
	assign zb_in = (64'(xb_s2) >= X_LIM);
	assign xt_num = zt_in ? '0 : xt_s2[SPAN_LOG-1:0];
	assign xb_num = zb_in ? '0 : xb_s2[SPAN_LOG-1:0];
	assign c1_in = '{rule: rule_s2, neg0: neg0_s2, flat: fl_sum[Q_W-1:16], zt: zt_in,
		zb: zb_in, xt: xt_num, xb: xb_num};

	st_div #(.W(Q_W), .DW(DEP_W), .CW($bits(c1_t))) u_div_q (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s2),
		.num({ks_s2, 24'd0}), .den(f_s2), .ctx_in(c1_in),
		.out_valid(v_g1), .quo(q_g1), .rem(), .ctx_out(c1_g1)
	);

	st_div #(.W(Q_W), .DW(DEP_W), .CW(1)) u_div_ratio (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s2),
		.num({dz_s2, 32'd0}), .den(dh_s2), .ctx_in(1'b0),
		.out_valid(), .quo(ratio_g1), .rem(), .ctx_out()
	);

	// ---- stage 3: table reads; index and remainder are the high and low bits
	logic [RAW-1:0] ita, itb, iba, ibb;
	logic v_s3;
	logic [E_W-1:0] ta0_s3, ta1_s3, ba0_s3, ba1_s3;
	logic [SH-1:0] rt_s3, rb_s3;
	logic [Q_W-1:0] q_s3;
	logic [R_W-1:0] ratio_s3;
	c1_t c1_s3;

	assign ita = RAW'(c1_g1.xt[SPAN_LOG-1:SH]);
	assign itb = ita + RAW'(1);
	assign iba = RAW'(c1_g1.xb[SPAN_LOG-1:SH]);
	assign ibb = iba + RAW'(1);
	assign rt_g1 = c1_g1.xt[SH-1:0];
	assign rb_g1 = c1_g1.xb[SH-1:0];

	// ---- stage 4: sample step
	logic v_s4;
	logic [E_W-1:0] td_s4, bd_s4, ta0_s4, ba0_s4;
	logic [SH-1:0] rt_s4, rb_s4;
	logic [Q_W-1:0] q_s4;
	logic [R_W-1:0] ratio_s4;
	c1_t c1_s4;

	// ---- stage 5: step times remainder
	logic v_s5;
	logic [G2_W-1:0] tp_s5, bp_s5;
	c2_t c2_s5;

	// ---- stages 6 to 11
	logic v_s6, v_s7, v_s8, v_s9, v_s10;
	logic [E_W-1:0] et_s6, eb_s6, diff_s7;
	logic nege_s7, nege_s8, nege_s9, nege_s10;
	logic [Q_W-1:0] q_s6, q_s7;
	logic [R_W-1:0] ratio_s6, ratio_s7, ratio_s8, ratio_s9;
	c1_t c1_s6, c1_s7, c1_s8, c1_s9, c1_s10;
	logic [60:0] ph_s8, pl_s8;
	logic [L_W-1:0] lay_s9, lay_s10;
	logic [56:0] hh_s10;
	logic [57:0] hl_s10;
	logic [89:0] lay_sum;
	logic [82:0] lin_sum;
	logic [50:0] lin;
	logic [T_W-1:0] t_next;
	logic c_next;
	logic v_s11;
	logic [T_W-1:0] t_s11;
	logic c_s11;

	assign lay_sum = 90'({ph_s8, 28'd0}) + 90'(pl_s8) + (90'd1 << 39);
	assign lin_sum = 83'({hh_s10, 25'd0}) + 83'(hl_s10) + (83'd1 << 31);
	assign lin = lin_sum[82:32];

	// pick the result for the rule, clamp and saturate
	always_comb begin
		t_next = '0;
		c_next = 1'b0;
		case (c1_s10.rule)
			RULE_FLAT: begin
				c_next = c1_s10.neg0;
				t_next = c1_s10.neg0 ? '0 : c1_s10.flat;
			end
			RULE_UPPER: begin
				c_next = nege_s10;
				if (!nege_s10) begin
					t_next = (lay_s10 > L_W'(T_MAX)) ? T_MAX : lay_s10[T_W-1:0];
				end
			end
			RULE_SHALLOW: begin
				c_next = 1'b0;
			end
			RULE_BAD: begin
				c_next = 1'b1;
			end
			RULE_LINEAR: begin
				c_next = nege_s10;
				if (!nege_s10) begin
					t_next = (lin > 51'(T_MAX)) ? T_MAX : lin[T_W-1:0];
				end
			end
			default: begin
				c_next = 1'b0;
			end
		endcase
	end

	// advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_g1;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
		end
	end

	// advance payload
	always_ff @(posedge clk) begin
		if (en) begin
			d_s1 <= soil_depth;
			z_s1 <= water_depth;
			h_s1 <= thresh_depth;
			f_s1 <= decay_rate;
			ks_s1 <= lateral_cond;
			rule_s1 <= rule_in;
			neg0_s1 <= (water_depth > soil_depth);

			xt_s2 <= f_s1 * top_s1;
			xb_s2 <= f_s1 * d_s1;
			fl_s2 <= ks_s1 * (d_s1 - z_s1);
			ks_s2 <= ks_s1;
			f_s2 <= f_s1;
			dz_s2 <= d_s1 - z_s1;
			dh_s2 <= d_s1 - h_s1;
			rule_s2 <= rule_s1;
			neg0_s2 <= neg0_s1;

			ta0_s3 <= EXP_ROM[ita];
			ta1_s3 <= EXP_ROM[itb];
			ba0_s3 <= EXP_ROM[iba];
			ba1_s3 <= EXP_ROM[ibb];
			rt_s3 <= rt_g1;
			rb_s3 <= rb_g1;
			q_s3 <= q_g1;
			ratio_s3 <= ratio_g1[R_W-1:0];
			c1_s3 <= c1_g1;

			td_s4 <= ta0_s3 - ta1_s3;
			bd_s4 <= ba0_s3 - ba1_s3;
			ta0_s4 <= ta0_s3;
			ba0_s4 <= ba0_s3;
			rt_s4 <= rt_s3;
			rb_s4 <= rb_s3;
			q_s4 <= q_s3;
			ratio_s4 <= ratio_s3;
			c1_s4 <= c1_s3;

			tp_s5 <= G2_W'(td_s4) * G2_W'(rt_s4);
			bp_s5 <= G2_W'(bd_s4) * G2_W'(rb_s4);
			c2_s5 <= '{at: ta0_s4, ab: ba0_s4, q: q_s4, ratio: ratio_s4, c1: c1_s4};

			// drop the low bits of step times remainder to interpolate
			et_s6 <= c2_s5.c1.zt ? '0 : c2_s5.at - tp_s5[SH +: E_W];
			eb_s6 <= c2_s5.c1.zb ? '0 : c2_s5.ab - bp_s5[SH +: E_W];
			q_s6 <= c2_s5.q;
			ratio_s6 <= c2_s5.ratio;
			c1_s6 <= c2_s5.c1;

			diff_s7 <= et_s6 - eb_s6;
			nege_s7 <= (et_s6 < eb_s6);
			q_s7 <= q_s6;
			ratio_s7 <= ratio_s6;
			c1_s7 <= c1_s6;

			ph_s8 <= q_s7[55:28] * diff_s7;
			pl_s8 <= q_s7[27:0] * diff_s7;
			nege_s8 <= nege_s7;
			ratio_s8 <= ratio_s7;
			c1_s8 <= c1_s7;

			lay_s9 <= lay_sum[88:40];
			nege_s9 <= nege_s8;
			ratio_s9 <= ratio_s8;
			c1_s9 <= c1_s8;

			hh_s10 <= lay_s9[48:25] * ratio_s9;
			hl_s10 <= lay_s9[24:0] * ratio_s9;
			lay_s10 <= lay_s9;
			nege_s10 <= nege_s9;
			c1_s10 <= c1_s9;

			t_s11 <= t_next;
			c_s11 <= c_next;
		end
	end

	assign out_valid = v_s11;
	assign transmissivity = t_s11;
	assign clamped = c_s11;

endmodule

@@ sv/st_check.sv @@
`include "soil_transmissivity_assert.svh"

module st_check (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic [st_pkg::T_W-1:0] transmissivity,
	input logic clamped
);

	// a clamped result always reads zero
	`ST_ASSERT_IMP(a_clamp_zero, out_valid && clamped, transmissivity == '0, "clamped result not zero")

	// input backs up only behind a stalled result
	`ST_ASSERT_IMP(a_stall_cause, in_stall, out_valid && out_stall, "input stalled without cause")

	// a stalled result holds
	`ST_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(transmissivity) && $stable(clamped), "stalled result changed")

endmodule

bind soil_transmissivity st_check u_st_check (.*);

@@ sim/soil_transmissivity_checker.sv @@
`timescale 1ns / 1ps

module soil_transmissivity_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic [st_pkg::DEP_W-1:0] soil_depth,
	input logic [st_pkg::DEP_W-1:0] water_depth,
	input logic [st_pkg::KS_W-1:0] lateral_cond,
	input logic [st_pkg::DEP_W-1:0] decay_rate,
	input logic [st_pkg::DEP_W-1:0] thresh_depth,
	input logic out_valid,
	input logic out_stall,
	input logic [st_pkg::T_W-1:0] transmissivity,
	input logic clamped,
	output int fails,
	output int pending
);
	import st_pkg::*;

	localparam int TBL_DEPTH = 256;
	localparam logic [63:0] STEP = SPAN / TBL_DEPTH;

	typedef struct {
		logic [T_W-1:0] trans;
		logic clamp;
	} result_t;

	result_t expected_q[$];
	logic [63:0] exp_tbl[0:TBL_DEPTH];

	// round half up of (a*b) / 2^s, keeping 64 bits
	function automatic logic [63:0] scaled_product(input logic [63:0] a, input logic [63:0] b,
		input int unsigned s);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		p = p + (128'd1 << (s - 1));
		p = p >> s;
		return p[63:0];
	endfunction

	// e^-x with x in Q16.32, result in Q0.32
	function automatic logic [63:0] decay_exp(input logic [63:0] x);
		logic [63:0] i, r, d;
		if (x >= STEP * TBL_DEPTH)
			return 64'd0;
		i = x / STEP;
		r = x % STEP;
		d = exp_tbl[i] - exp_tbl[i + 1];
		return exp_tbl[i] - (d * r) / STEP;
	endfunction

	// (Ks/f) * (e^-f*top - e^-f*bot); flags a negative difference
	function automatic logic [63:0] layer_flux(input logic [63:0] ks, input logic [63:0] f,
		input logic [63:0] top, input logic [63:0] bot, inout logic neg);
		logic [63:0] et, eb, q;
		et = decay_exp(f * top);
		eb = decay_exp(f * bot);
		q = (ks << 24) / f;
		if (et < eb) begin
			neg = 1'b1;
			return 64'd0;
		end
		return scaled_product(q, et - eb, 40);
	endfunction

	function automatic result_t transmissivity_of(input logic [63:0] dep, input logic [63:0] wat,
		input logic [63:0] ks, input logic [63:0] f, input logic [63:0] thr);
		result_t res;
		logic [63:0] t, th, ratio;
		logic neg;
		t = 0;
		neg = 1'b0;
		if (f == 0) begin
			if (wat > dep)
				neg = 1'b1;
			else
				t = (ks * (dep - wat) + 64'd32768) >> 16;
		end else if (wat < thr) begin
			t = layer_flux(ks, f, wat, dep, neg);
		end else if (dep < thr) begin
			t = 0;
		end else if (dep == thr || wat > dep) begin
			neg = 1'b1;
		end else begin
			th = layer_flux(ks, f, thr, dep, neg);
			ratio = ((dep - wat) << 32) / (dep - thr);
			t = neg ? 64'd0 : scaled_product(th, ratio, 32);
		end
		if (neg)
			t = 0;
		if (t > {24'd0, T_MAX})
			t = {24'd0, T_MAX};
		res.trans = t[T_W-1:0];
		res.clamp = neg;
		return res;
	endfunction

	// build the exponential table from a series for one step
	initial begin
		logic [63:0] u62, term, sum, t62;
		u62 = STEP << 30;
		term = 64'd1 << 62;
		sum = term;
		for (int n = 1; n <= 24; n++) begin
			term = scaled_product(term, u62, 62) / n;
			if (n % 2 == 1)
				sum = sum - term;
			else
				sum = sum + term;
		end
		t62 = 64'd1 << 62;
		exp_tbl[0] = 64'd1 << 32;
		for (int k = 1; k <= TBL_DEPTH; k++) begin
			t62 = scaled_product(t62, sum, 62);
			exp_tbl[k] = (t62 + (64'd1 << 29)) >> 30;
		end
	end

	initial fails = 0;
	assign pending = expected_q.size();

	// predict on input transfers, compare on output transfers
	always @(posedge clk) begin
		result_t want;
		if (arst_n && in_valid && !in_stall)
			expected_q.push_back(transmissivity_of(soil_depth, water_depth, lateral_cond,
				decay_rate, thresh_depth));
		if (arst_n && out_valid && !out_stall) begin
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result trans=%0d clamped=%0b", $time,
					transmissivity, clamped);
				fails <= fails + 1;
			end else begin
				want = expected_q.pop_front();
				if (want.trans !== transmissivity || want.clamp !== clamped) begin
					$display("%0t: mismatch expected trans=%0d clamped=%0b, got trans=%0d clamped=%0b",
						$time, want.trans, want.clamp, transmissivity, clamped);
					fails <= fails + 1;
				end
			end
		end
	end

endmodule

@@ sim/soil_transmissivity_test.sv @@
`timescale 1ns / 1ps

module soil_transmissivity_test;
	import st_pkg::*;

	localparam int RANDOM_ITEMS = 1830;
	localparam int CYCLE_LIMIT = 1000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [DEP_W-1:0] soil_depth = '0;
	logic [DEP_W-1:0] water_depth = '0;
	logic [KS_W-1:0] lateral_cond = '0;
	logic [DEP_W-1:0] decay_rate = '0;
	logic [DEP_W-1:0] thresh_depth = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [T_W-1:0] transmissivity;
	logic clamped;
	int fails, pending;
	int cycles = 0;
	int sent = 0;
	bit quiet = 0;

	soil_transmissivity uut (.*);

	soil_transmissivity_checker chk (.*);

	always #4 clk = ~clk;

	// abort a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("soil_transmissivity regression: fail");
			$finish;
		end
	end

	function automatic logic [23:0] rand_depth();
		int w;
		w = $urandom_range(1, 24);
		return 24'($urandom) & ((24'd1 << w) - 24'd1) | (w == 24 ? 24'h800000 : 24'd0);
	endfunction

	function automatic logic [23:0] rand_rate();
		// mostly up to a few per meter so exponents stay in the table
		if ($urandom_range(0, 9) < 8)
			return 24'($urandom_range(1, 1 << 19));
		return 24'($urandom);
	endfunction

	// wait out a random gap, then offer one item until it transfers
	task automatic offer(input logic [23:0] d, input logic [23:0] w, input logic [31:0] k,
		input logic [23:0] f, input logic [23:0] h);
		int gap, r;
		r = $urandom_range(0, 99);
		gap = quiet ? 0 : (r < 60 ? 0 : (r < 95 ? $urandom_range(1, 3) : $urandom_range(10, 80)));
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		soil_depth <= d;
		water_depth <= w;
		lateral_cond <= k;
		decay_rate <= f;
		thresh_depth <= h;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sent++;
	endtask

	// random item of one of the rule shapes
	task automatic offer_random();
		logic [23:0] d, w, f, h, a, b, c;
		logic [31:0] k;
		int kind;
		kind = $urandom_range(0, 9);
		k = $urandom;
		a = rand_depth();
		b = rand_depth();
		c = rand_depth();
		// sort so that a <= b <= c
		if (a > b) {a, b} = {b, a};
		if (b > c) {b, c} = {c, b};
		if (a > b) {a, b} = {b, a};
		f = rand_rate();
		case (kind)
			0: offer(24'($urandom), 24'($urandom), k, 24'($urandom), 24'($urandom));
			1: begin
				if ($urandom_range(0, 3) == 0)
					offer(a, c, k, 24'd0, b);
				else
					offer(c, a, k, 24'd0, b);
			end
			2, 3: offer(c, a, k, f, b);
			4, 5, 6: offer(c, b, k, f, a);
			7: offer(a, c, k, f, b);
			8: offer(b, c, k, f, b);
			default: offer(b, c, k, f, a);
		endcase
	endtask

	// receiver: random stalls, one long hold, and quiet stretches
	initial begin
		int r, hold;
		hold = 0;
		forever begin
			@(posedge clk);
			if (sent >= 600 && hold == 0)
				hold = 600;
			if (hold > 0) begin
				out_stall <= 1'b1;
				hold--;
				if (hold == 0)
					hold = -1;
			end else if (quiet) begin
				out_stall <= 1'b0;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 97)
					out_stall <= (r >= 70);
				else begin
					out_stall <= 1'b1;
					repeat ($urandom_range(10, 80)) @(posedge clk);
				end
			end
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// extremes and each rule
		offer(24'd0, 24'd0, 32'd0, 24'd0, 24'd0);
		offer(24'hFFFFFF, 24'd0, 32'hFFFFFFFF, 24'd0, 24'd0);
		offer(24'd0, 24'hFFFFFF, 32'hFFFFFFFF, 24'd0, 24'd0);
		offer(24'hFFFFFF, 24'hFFFFFF, 32'hFFFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
		offer(24'hFFFFFF, 24'd0, 32'hFFFFFFFF, 24'd1, 24'hFFFFFF);
		offer(24'h020000, 24'h008000, 32'h10000000, 24'h010000, 24'h010000);
		offer(24'h040000, 24'h000000, 32'hFFFFFFFF, 24'h000001, 24'h000001);
		offer(24'h200000, 24'h000000, 32'h80000000, 24'h200000, 24'h010000);
		offer(24'h030000, 24'h020000, 32'h01000000, 24'h008000, 24'h010000);
		offer(24'h030000, 24'h030000, 32'h01000000, 24'h008000, 24'h010000);
		offer(24'h010000, 24'h030000, 32'h01000000, 24'h008000, 24'h020000);
		offer(24'h020000, 24'h030000, 32'h01000000, 24'h008000, 24'h020000);
		offer(24'h020000, 24'h030000, 32'h01000000, 24'h008000, 24'h010000);
		offer(24'h030000, 24'h010000, 32'h01000000, 24'h008000, 24'h020000);
		offer(24'h030000, 24'h010000, 32'h01000000, 24'h000000, 24'h020000);
		offer(24'hFFFFFF, 24'hFFFFFE, 32'hFFFFFFFF, 24'h000001, 24'h000000);
		offer(24'h100000, 24'h000000, 32'hFFFFFFFF, 24'h000002, 24'h0FFFFF);
		// random traffic, with a back to back stretch in the middle
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			quiet = (n >= 1200 && n < 1400);
			offer_random();
		end
		quiet = 0;
		in_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (fails == 0)
			$display("soil_transmissivity regression: pass");
		else
			$display("soil_transmissivity regression: fail");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+sv
sv/st_pkg.sv
sv/st_div.sv
sv/soil_transmissivity.sv
sv/st_check.sv
sim/soil_transmissivity_checker.sv
sim/soil_transmissivity_test.sv
